FILE: rtl/dnsap_pkg.sv
// ----------------------------------------------------------------------------
// dnsap_pkg
// Shared types and constants for the DNS response A-record parser.
// ----------------------------------------------------------------------------
package dnsap_pkg;

	// Header length in bytes and the id register value after reset
	localparam int unsigned HEADER_BYTES = 12;
	localparam logic [15:0] TID_RESET    = 16'h1234;

	// Default depth of the result buffer
	localparam int unsigned RES_DEPTH = 3;

	// Top two bits set on a name byte mark a compression pointer
	localparam logic [7:0] PTR_MASK = 8'hC0;

	// Record attributes that make an A record
	localparam logic [15:0] TYPE_A   = 16'd1;
	localparam logic [15:0] CLASS_IN = 16'd1;
	localparam logic [15:0] LEN_IPV4 = 16'd4;

	// Packet status codes
	typedef enum logic [2:0] {
		ST_RESOLVED  = 3'd0,
		ST_SHORT     = 3'd1,
		ST_ID        = 3'd2,
		ST_NOT_RESP  = 3'd3,
		ST_NO_ANSWER = 3'd4,
		ST_NO_A      = 3'd5,
		ST_TRUNC     = 3'd6
	} status_t;

	// One input transaction
	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	// One result transaction
	typedef struct packed {
		status_t     status;
		logic [31:0] address;
		logic        resolved;
	} result_t;

endpackage

FILE: rtl/dnsap_msg_if.sv
// ----------------------------------------------------------------------------
// dnsap_msg_if
// Byte channel into the parser: valid/ready plus one message byte.
// ----------------------------------------------------------------------------
interface dnsap_msg_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, action, data_byte, last_byte, input ready);
	modport sink   (input valid, action, data_byte, last_byte, output ready);
endinterface

FILE: rtl/dnsap_res_if.sv
// ----------------------------------------------------------------------------
// dnsap_res_if
// Result channel out of the parser: valid/ready plus status and address.
// ----------------------------------------------------------------------------
interface dnsap_res_if;
	logic               valid;
	logic               ready;
	dnsap_pkg::status_t status;
	logic [31:0]        address;
	logic               resolved;

	modport source (output valid, status, address, resolved, input ready);
	modport sink   (input valid, status, address, resolved, output ready);
endinterface

FILE: rtl/dns_response_a_record_parser_top.sv
// ----------------------------------------------------------------------------
// dns_response_a_record_parser_top
// Parses a DNS response byte stream and reports the first A record address.
//
//   channel          dir  handshake        payload
//   msg              in   valid/ready      action, data_byte, last_byte
//   res              out  valid/ready      status, address, resolved
//   transaction_id   in   transaction_id_we  16-bit expected header id
//
// One byte per cycle while msg.ready is high. A byte is registered on
// acceptance and parsed the next cycle; a last byte's parse pushes its result
// into the queue. The queue depth (ResDepth) sets how long the result side may
// stall before msg.ready drops. arst_n clears all control and parse state,
// the held address and flag, and loads the id register to 0x1234.
// ----------------------------------------------------------------------------
module dns_response_a_record_parser_top #(
	parameter int unsigned ResDepth = dnsap_pkg::RES_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 transaction_id_we,
	input  logic [15:0]          transaction_id,
	dnsap_msg_if.sink            msg,
	dnsap_res_if.source          res
);

	localparam int unsigned LvlW = $clog2(ResDepth + 1);

	dnsap_pkg::item_t   item;
	dnsap_pkg::result_t res_data, head;
	logic               accept, busy_s1, res_push, not_empty, pop;
	logic [LvlW-1:0]    level;

	assign item.action    = msg.action;
	assign item.data_byte = msg.data_byte;
	assign item.last_byte = msg.last_byte;
	assign accept         = msg.valid && msg.ready;

	// Accept only while a queue slot stays free for every transaction in flight
	assign msg.ready = ((LvlW + 1)'(level) + (LvlW + 1)'(busy_s1))
		<= (LvlW + 1)'(ResDepth - 1);

	assign pop          = res.valid && res.ready;
	assign res.valid    = not_empty;
	assign res.status   = head.status;
	assign res.address  = head.address;
	assign res.resolved = head.resolved;

	dnsap_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.tid_we     (transaction_id_we),
		.tid_wdata  (transaction_id),
		.item_valid (accept),
		.item       (item),
		.busy_s1    (busy_s1),
		.res_push   (res_push),
		.res_data   (res_data)
	);

	dnsap_res_buf #(
		.Depth (ResDepth)
	) u_res_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head),
		.level     (level)
	);

endmodule

FILE: rtl/dnsap_core.sv
// ----------------------------------------------------------------------------
// dnsap_core
// Input register and per-byte parse logic; one result per non-clear last byte.
// ----------------------------------------------------------------------------
module dnsap_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tid_we,
	input  logic [15:0]         tid_wdata,
	input  logic                item_valid,
	input  dnsap_pkg::item_t    item,
	output logic                busy_s1,
	output logic                res_push,
	output dnsap_pkg::result_t  res_data
);

	typedef enum logic [3:0] {
		PH_HEADER, PH_QNAME, PH_QLABEL, PH_QPTR, PH_QFIXED,
		PH_ANAME, PH_ALABEL, PH_APTR, PH_AFIXED, PH_ADATA, PH_DONE
	} phase_t;

	// Input stage
	logic             valid_s1;
	dnsap_pkg::item_t item_s1;

	// Parse state
	logic [15:0] tid_q;
	phase_t      phase_q, n_phase;
	logic [3:0]  hpos_q, n_hpos;
	logic [2:0]  verdict_q, n_verdict;
	logic [15:0] qleft_q, n_qleft;
	logic [15:0] aleft_q, n_aleft;
	logic [7:0]  lbl_q, n_lbl;
	logic [3:0]  fixed_q, n_fixed;
	logic [15:0] rtype_q, n_rtype;
	logic [15:0] rclass_q, n_rclass;
	logic [15:0] rlen_q, n_rlen;
	logic [15:0] dleft_q, n_dleft;
	logic [31:0] shift_q, n_shift;
	logic [31:0] raddr_q, n_raddr;
	logic        rflag_q, n_rflag;
	logic        found_q, n_found;

	logic [7:0]         b;
	logic               name_zero, name_ptr;
	dnsap_pkg::status_t status;

	assign b         = item_s1.data_byte;
	assign name_zero = (b == 8'd0);
	assign name_ptr  = ((b & dnsap_pkg::PTR_MASK) == dnsap_pkg::PTR_MASK);
	assign busy_s1   = valid_s1;

	// Advance the parse state by one byte, or clear the held address and flag
	always_comb begin
		n_phase   = phase_q;
		n_hpos    = hpos_q;
		n_verdict = verdict_q;
		n_qleft   = qleft_q;
		n_aleft   = aleft_q;
		n_lbl     = lbl_q;
		n_fixed   = fixed_q;
		n_rtype   = rtype_q;
		n_rclass  = rclass_q;
		n_rlen    = rlen_q;
		n_dleft   = dleft_q;
		n_shift   = shift_q;
		n_raddr   = raddr_q;
		n_rflag   = rflag_q;
		n_found   = found_q;
		res_push  = 1'b0;
		status    = dnsap_pkg::ST_TRUNC;

		if (valid_s1 && item_s1.action) begin
			// Clear the held address and flag only
			n_raddr = '0;
			n_rflag = 1'b0;
		end else if (valid_s1) begin
			unique case (phase_q)
				PH_HEADER: begin
					unique case (hpos_q)
						4'd0: n_rtype = {b, 8'h00};
						4'd1: begin
							if ({rtype_q[15:8], b} != tid_q && verdict_q == 3'd0)
								n_verdict = dnsap_pkg::ST_ID;
						end
						4'd2: begin
							if (!b[7] && verdict_q == 3'd0)
								n_verdict = dnsap_pkg::ST_NOT_RESP;
						end
						4'd4: n_qleft = {b, 8'h00};
						4'd5: n_qleft = {qleft_q[15:8], b};
						4'd6: n_aleft = {b, 8'h00};
						4'd7: begin
							n_aleft = {aleft_q[15:8], b};
							if ({aleft_q[15:8], b} == 16'd0 && verdict_q == 3'd0)
								n_verdict = dnsap_pkg::ST_NO_ANSWER;
						end
						default: ;
					endcase
					n_hpos = hpos_q + 4'd1;
					if (hpos_q == 4'(dnsap_pkg::HEADER_BYTES - 1)) begin
						n_rtype = '0;
						if (verdict_q != 3'd0)
							n_phase = PH_DONE;
						else
							n_phase = (qleft_q != 16'd0) ? PH_QNAME : PH_ANAME;
					end
				end
				PH_QNAME, PH_ANAME: begin
					priority if (name_zero) begin
						n_phase = (phase_q == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
						n_fixed = '0;
					end else if (name_ptr) begin
						n_phase = (phase_q == PH_QNAME) ? PH_QPTR : PH_APTR;
					end else begin
						n_lbl   = b;
						n_phase = (phase_q == PH_QNAME) ? PH_QLABEL : PH_ALABEL;
					end
				end
				PH_QLABEL, PH_ALABEL: begin
					n_lbl = lbl_q - 8'd1;
					if (lbl_q == 8'd1)
						n_phase = (phase_q == PH_QLABEL) ? PH_QNAME : PH_ANAME;
				end
				PH_QPTR: begin
					n_phase = PH_QFIXED;
					n_fixed = '0;
				end
				PH_APTR: begin
					n_phase = PH_AFIXED;
					n_fixed = '0;
				end
				PH_QFIXED: begin
					n_fixed = fixed_q + 4'd1;
					if (fixed_q == 4'd3) begin
						n_fixed = '0;
						n_qleft = qleft_q - 16'd1;
						if (qleft_q != 16'd1)
							n_phase = PH_QNAME;
						else
							n_phase = (aleft_q != 16'd0) ? PH_ANAME : PH_DONE;
					end
				end
				PH_AFIXED: begin
					unique case (fixed_q)
						4'd0: n_rtype  = {b, 8'h00};
						4'd1: n_rtype  = {rtype_q[15:8], b};
						4'd2: n_rclass = {b, 8'h00};
						4'd3: n_rclass = {rclass_q[15:8], b};
						4'd8: n_rlen   = {b, 8'h00};
						4'd9: n_rlen   = {rlen_q[15:8], b};
						default: ;
					endcase
					n_fixed = fixed_q + 4'd1;
					if (fixed_q == 4'd9) begin
						n_fixed = '0;
						n_dleft = {rlen_q[15:8], b};
						n_shift = '0;
						if ({rlen_q[15:8], b} != 16'd0) begin
							n_phase = PH_ADATA;
						end else begin
							n_aleft = aleft_q - 16'd1;
							n_phase = (aleft_q != 16'd1) ? PH_ANAME : PH_DONE;
						end
					end
				end
				PH_ADATA: begin
					n_shift = {shift_q[23:0], b};
					n_dleft = dleft_q - 16'd1;
					if (dleft_q == 16'd1) begin
						if (rtype_q == dnsap_pkg::TYPE_A && rclass_q == dnsap_pkg::CLASS_IN
								&& rlen_q == dnsap_pkg::LEN_IPV4) begin
							n_raddr = {shift_q[23:0], b};
							n_rflag = 1'b1;
							n_found = 1'b1;
							n_phase = PH_DONE;
						end else begin
							n_aleft = aleft_q - 16'd1;
							n_phase = (aleft_q != 16'd1) ? PH_ANAME : PH_DONE;
						end
					end
				end
				default: ;
			endcase

			// Report on the last byte, then drop the per-packet state
			if (item_s1.last_byte) begin
				res_push = 1'b1;
				priority if (n_phase == PH_HEADER)
					status = dnsap_pkg::ST_SHORT;
				else if (n_verdict != 3'd0)
					status = dnsap_pkg::status_t'(n_verdict);
				else if (n_found)
					status = dnsap_pkg::ST_RESOLVED;
				else if (n_phase == PH_DONE)
					status = dnsap_pkg::ST_NO_A;
				else
					status = dnsap_pkg::ST_TRUNC;
				n_phase   = PH_HEADER;
				n_hpos    = '0;
				n_verdict = '0;
				n_qleft   = '0;
				n_aleft   = '0;
				n_lbl     = '0;
				n_fixed   = '0;
				n_rtype   = '0;
				n_rclass  = '0;
				n_rlen    = '0;
				n_dleft   = '0;
				n_shift   = '0;
				n_found   = 1'b0;
			end
		end
	end

	assign res_data.status   = status;
	assign res_data.address  = n_raddr;
	assign res_data.resolved = n_rflag;

	// Hold input stage, id register and parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			tid_q     <= dnsap_pkg::TID_RESET;
			phase_q   <= PH_HEADER;
			hpos_q    <= '0;
			verdict_q <= '0;
			qleft_q   <= '0;
			aleft_q   <= '0;
			lbl_q     <= '0;
			fixed_q   <= '0;
			rtype_q   <= '0;
			rclass_q  <= '0;
			rlen_q    <= '0;
			dleft_q   <= '0;
			shift_q   <= '0;
			raddr_q   <= '0;
			rflag_q   <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			valid_s1  <= item_valid;
			if (tid_we)
				tid_q <= tid_wdata;
			phase_q   <= n_phase;
			hpos_q    <= n_hpos;
			verdict_q <= n_verdict;
			qleft_q   <= n_qleft;
			aleft_q   <= n_aleft;
			lbl_q     <= n_lbl;
			fixed_q   <= n_fixed;
			rtype_q   <= n_rtype;
			rclass_q  <= n_rclass;
			rlen_q    <= n_rlen;
			dleft_q   <= n_dleft;
			shift_q   <= n_shift;
			raddr_q   <= n_raddr;
			rflag_q   <= n_rflag;
			found_q   <= n_found;
		end
	end

	// Payload of the input stage needs no reset
	always_ff @(posedge clk) begin
		if (item_valid)
			item_s1 <= item;
	end

	// A clear transaction never yields a result
	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.action) |-> !res_push)
		else $error("result pushed on a clear transaction");

	// Every result restarts the packet at the header
	a_result_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (phase_q == PH_HEADER && hpos_q == 4'd0 && !found_q))
		else $error("packet state not restarted after a result");

	// The held flag and address are both zero after a clear
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.action) |=> (!rflag_q && raddr_q == 32'd0))
		else $error("clear did not drop the held address");

endmodule

FILE: rtl/dnsap_res_buf.sv
// ----------------------------------------------------------------------------
// dnsap_res_buf
// Small result queue between the parse logic and the result channel.
// ----------------------------------------------------------------------------
module dnsap_res_buf #(
	parameter int unsigned Depth = dnsap_pkg::RES_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  dnsap_pkg::result_t               push_data,
	input  logic                             pop,
	output logic                             not_empty,
	output dnsap_pkg::result_t               head,
	output logic [$clog2(Depth + 1) - 1:0]   level
);

	localparam int unsigned PtrW = $clog2(Depth);
	localparam int unsigned LvlW = $clog2(Depth + 1);

	dnsap_pkg::result_t entry_q [Depth];
	logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [LvlW-1:0]    count_q;

	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign level     = count_q;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + LvlW'(1);
				2'b01:   count_q <= count_q - LvlW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	// Never push into a full queue unless a pop frees a slot in the same cycle
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < LvlW'(Depth) || pop))
		else $error("result queue overflow");

	// Never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("result queue underflow");

endmodule

FILE: verif/dnsap_answer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dnsap_answer_checker
// Watches the byte and result channels of the DNS A-record parser, tracks the
// parse of every accepted byte, and compares each result transaction with the
// oldest predicted report. Mismatch and pending counts go to the bench top.
// ----------------------------------------------------------------------------
module dnsap_answer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tid_we,
	input  logic [15:0] tid_value,
	dnsap_msg_if        msg,
	dnsap_res_if        res,
	output int          errors,
	output int          outstanding
);
	import dnsap_pkg::*;

	typedef enum logic [3:0] {
		WALK_HDR, WALK_QNAME, WALK_QLABEL, WALK_QPTR, WALK_QFIXED,
		WALK_ANAME, WALK_ALABEL, WALK_APTR, WALK_AFIXED, WALK_ADATA, WALK_DONE
	} walk_e;

	// Shadow of the parser state
	walk_e       walk;
	logic [3:0]  hdr_pos;
	status_t     hdr_fail;	// ST_RESOLVED here means no header check failed yet
	logic [15:0] id_reg;
	logic [15:0] qd_left;
	logic [15:0] an_left;
	logic [7:0]  label_left;
	logic [3:0]  fix_pos;
	logic [15:0] rr_type;
	logic [15:0] rr_class;
	logic [15:0] rr_len;
	logic [15:0] rd_left;
	logic [31:0] addr_acc;
	logic [31:0] held_addr;
	logic        held_flag;
	logic        hit_this;

	result_t reports[$];
	int      bad = 0;
	int      depth = 0;

	assign errors      = bad;
	assign outstanding = depth;

	// Drop all per-packet state; the held address and flag survive
	task automatic restart_packet();
		walk       = WALK_HDR;
		hdr_pos    = '0;
		hdr_fail   = ST_RESOLVED;
		qd_left    = '0;
		an_left    = '0;
		label_left = '0;
		fix_pos    = '0;
		rr_type    = '0;
		rr_class   = '0;
		rr_len     = '0;
		rd_left    = '0;
		addr_acc   = '0;
		hit_this   = 1'b0;
	endtask

	// One byte of a name: end mark, compression pointer or label length
	task automatic name_step(input logic [7:0] b, input walk_e lbl, input walk_e ptr,
			input walk_e fix);
		if (b == 8'h00) begin
			walk    = fix;
			fix_pos = '0;
		end else if ((b & PTR_MASK) == PTR_MASK) begin
			walk = ptr;
		end else begin
			label_left = b;
			walk       = lbl;
		end
	endtask

	// Move on to the next answer or finish the walk
	task automatic next_answer();
		an_left = an_left - 16'd1;
		walk    = (an_left != 16'd0) ? WALK_ANAME : WALK_DONE;
	endtask

	// Advance the parse by one message byte
	task automatic track_byte(input logic [7:0] b);
		case (walk)
			WALK_HDR: begin
				// id at 0..1, flags at 2..3, question count at 4..5, answer count at 6..7
				case (hdr_pos)
					4'd0: rr_type = {b, 8'h00};
					4'd1: if ({rr_type[15:8], b} != id_reg && hdr_fail == ST_RESOLVED)
						hdr_fail = ST_ID;
					4'd2: if (!b[7] && hdr_fail == ST_RESOLVED) hdr_fail = ST_NOT_RESP;
					4'd4: qd_left = {b, 8'h00};
					4'd5: qd_left[7:0] = b;
					4'd6: an_left = {b, 8'h00};
					4'd7: begin
						an_left[7:0] = b;
						if (an_left == 16'd0 && hdr_fail == ST_RESOLVED) hdr_fail = ST_NO_ANSWER;
					end
					default: ;
				endcase
				hdr_pos = hdr_pos + 4'd1;
				if (hdr_pos >= HEADER_BYTES) begin
					rr_type = '0;
					if (hdr_fail != ST_RESOLVED) walk = WALK_DONE;
					else walk = (qd_left != 16'd0) ? WALK_QNAME : WALK_ANAME;
				end
			end
			WALK_QNAME: name_step(b, WALK_QLABEL, WALK_QPTR, WALK_QFIXED);
			WALK_QLABEL: begin
				label_left = label_left - 8'd1;
				if (label_left == 8'd0) walk = WALK_QNAME;
			end
			WALK_QPTR: begin
				walk    = WALK_QFIXED;
				fix_pos = '0;
			end
			WALK_QFIXED: begin
				fix_pos = fix_pos + 4'd1;
				if (fix_pos >= 4'd4) begin
					fix_pos = '0;
					qd_left = qd_left - 16'd1;
					if (qd_left != 16'd0) walk = WALK_QNAME;
					else walk = (an_left != 16'd0) ? WALK_ANAME : WALK_DONE;
				end
			end
			WALK_ANAME: name_step(b, WALK_ALABEL, WALK_APTR, WALK_AFIXED);
			WALK_ALABEL: begin
				label_left = label_left - 8'd1;
				if (label_left == 8'd0) walk = WALK_ANAME;
			end
			WALK_APTR: begin
				walk    = WALK_AFIXED;
				fix_pos = '0;
			end
			WALK_AFIXED: begin
				// type at 0..1, class at 2..3, ttl at 4..7, data length at 8..9
				case (fix_pos)
					4'd0: rr_type = {b, 8'h00};
					4'd1: rr_type[7:0] = b;
					4'd2: rr_class = {b, 8'h00};
					4'd3: rr_class[7:0] = b;
					4'd8: rr_len = {b, 8'h00};
					4'd9: rr_len[7:0] = b;
					default: ;
				endcase
				fix_pos = fix_pos + 4'd1;
				if (fix_pos >= 4'd10) begin
					fix_pos  = '0;
					rd_left  = rr_len;
					addr_acc = '0;
					if (rd_left != 16'd0) walk = WALK_ADATA;
					else next_answer();
				end
			end
			WALK_ADATA: begin
				addr_acc = {addr_acc[23:0], b};
				rd_left  = rd_left - 16'd1;
				if (rd_left == 16'd0) begin
					if (rr_type == TYPE_A && rr_class == CLASS_IN && rr_len == LEN_IPV4) begin
						held_addr = addr_acc;
						held_flag = 1'b1;
						hit_this  = 1'b1;
						walk      = WALK_DONE;
					end else begin
						next_answer();
					end
				end
			end
			default: ;
		endcase
	endtask

	// Track register writes, predict reports and check result transactions
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		status_t code;
		if (!arst_n) begin
			id_reg    = TID_RESET;
			held_addr = '0;
			held_flag = 1'b0;
			restart_packet();
			reports.delete();
		end else begin
			if (tid_we) id_reg = tid_value;

			// Compare a result transaction with the oldest report
			if (res.valid && res.ready) begin
				if (reports.size() == 0) begin
					$display("%0t: result with none expected: status %0d address %h resolved %b",
						$time, res.status, res.address, res.resolved);
					bad++;
				end else begin
					want = reports.pop_front();
					if (res.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time, want.status,
							res.status);
						bad++;
					end
					if (res.address !== want.address) begin
						$display("%0t: address expected %h actual %h", $time, want.address,
							res.address);
						bad++;
					end
					if (res.resolved !== want.resolved) begin
						$display("%0t: resolved expected %b actual %b", $time, want.resolved,
							res.resolved);
						bad++;
					end
				end
			end

			// Predict from an accepted byte transaction
			if (msg.valid && msg.ready) begin
				if (msg.action) begin
					held_addr = '0;
					held_flag = 1'b0;
				end else begin
					track_byte(msg.data_byte);
					if (msg.last_byte) begin
						if (walk == WALK_HDR) code = ST_SHORT;
						else if (hdr_fail != ST_RESOLVED) code = hdr_fail;
						else if (hit_this) code = ST_RESOLVED;
						else if (walk == WALK_DONE) code = ST_NO_A;
						else code = ST_TRUNC;
						want = '{status: code, address: held_addr, resolved: held_flag};
						reports.push_back(want);
						restart_packet();
					end
				end
			end
		end
		depth = reports.size();
	end

endmodule

FILE: verif/dns_response_a_record_parser_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dns_response_a_record_parser_top_tb
// Feeds DNS responses byte by byte into the parser: a few hand-picked packets,
// then random well-formed, broken and truncated responses under several ids,
// with random gaps on both channels. A checker predicts and compares results.
// ----------------------------------------------------------------------------
module dns_response_a_record_parser_top_tb;
	import dnsap_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_BYTES = 400;

	typedef enum {
		RSP_GOOD, RSP_NO_A, RSP_TRUNC, RSP_BAD_ID, RSP_NOT_RESP, RSP_NO_ANS, RSP_SHORT,
		RSP_NOISE
	} pkt_kind_e;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        tid_we;
	logic [15:0] tid_data;
	logic [15:0] cur_tid;
	bit          calm = 1'b0;
	int          sent = 0;
	int          quiet = 0;
	int          chk_errors;
	int          chk_outstanding;
	logic [7:0]  pkt_q[$];

	dnsap_msg_if msg_ch ();
	dnsap_res_if res_ch ();

	dns_response_a_record_parser_top u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.transaction_id_we (tid_we),
		.transaction_id    (tid_data),
		.msg               (msg_ch),
		.res               (res_ch)
	);

	dnsap_answer_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.tid_we      (tid_we),
		.tid_value   (tid_data),
		.msg         (msg_ch),
		.res         (res_ch),
		.errors      (chk_errors),
		.outstanding (chk_outstanding)
	);

	always #2 clk = ~clk;

	// Mostly no gap, some short ones, a few long ones; none in calm stretches
	function automatic int pick_gap(input int longest);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, longest);
	endfunction

	// Offer one transaction and hold it until accepted
	task automatic push_byte(input logic act, input logic [7:0] b, input logic lst);
		int gap;
		gap = pick_gap(40);
		if (gap != 0) begin
			msg_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		msg_ch.valid     <= 1'b1;
		msg_ch.action    <= act;
		msg_ch.data_byte <= b;
		msg_ch.last_byte <= lst;
		@(posedge clk);
		while (!msg_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Send the built message, with an occasional clear slipped in
	task automatic send_packet();
		calm = ($urandom_range(0, 7) == 0);
		foreach (pkt_q[i]) begin
			if ($urandom_range(0, 39) == 0) push_byte(1'b1, 8'($urandom), 1'($urandom));
			push_byte(1'b0, pkt_q[i], i == pkt_q.size() - 1);
			sent++;
		end
	endtask

	task automatic add_u16(input logic [15:0] v);
		pkt_q.push_back(v[15:8]);
		pkt_q.push_back(v[7:0]);
	endtask

	// Name of up to two labels, ended by a zero byte or a pointer
	task automatic add_name();
		int labels;
		int len;
		int r;
		labels = $urandom_range(0, 2);
		repeat (labels) begin
			r = $urandom_range(0, 99);
			if (r < 97) len = $urandom_range(1, 6);
			else if (r < 99) len = $urandom_range(64, 190);
			else len = 191;
			pkt_q.push_back(8'(len));
			repeat (len) pkt_q.push_back(8'($urandom));
		end
		if ($urandom_range(0, 1) != 0) begin
			pkt_q.push_back({2'b11, 6'($urandom)});
			pkt_q.push_back(8'($urandom));
		end else begin
			pkt_q.push_back(8'h00);
		end
	endtask

	// Answer body that is not an IPv4 record, or only rarely by chance
	task automatic add_other_record();
		int r;
		int len;
		logic [15:0] rt;
		logic [15:0] rc;
		r = $urandom_range(0, 3);
		case (r)
			0: begin
				rt  = TYPE_A;
				rc  = CLASS_IN;
				len = $urandom_range(0, 8);
				if (len == 4) len = 5;
			end
			1: begin
				rt  = TYPE_A;
				rc  = 16'($urandom_range(2, 65535));
				len = 4;
			end
			2: begin
				rt  = 16'($urandom_range(2, 65535));
				rc  = CLASS_IN;
				len = 4;
			end
			default: begin
				rt  = 16'($urandom);
				rc  = 16'($urandom);
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 300)
					: $urandom_range(0, 16);
			end
		endcase
		add_u16(rt);
		add_u16(rc);
		add_u16(16'($urandom));
		add_u16(16'($urandom));
		add_u16(16'(len));
		repeat (len) pkt_q.push_back(8'($urandom));
	endtask

	// Build one message of the given flavor into pkt_q
	task automatic make_response(input pkt_kind_e kind, input logic [31:0] addr);
		int qd;
		int an;
		int qd_n;
		int an_n;
		int hit;
		int cut;
		logic [15:0] id;
		logic [7:0]  flags;
		pkt_q.delete();
		if (kind == RSP_SHORT || kind == RSP_NOISE) begin
			repeat ((kind == RSP_SHORT) ? $urandom_range(1, 11) : $urandom_range(1, 40))
				pkt_q.push_back(8'($urandom));
			return;
		end

		// Header
		id    = (kind == RSP_BAD_ID) ? cur_tid ^ 16'($urandom_range(1, 65535)) : cur_tid;
		flags = 8'($urandom);
		if (kind == RSP_NOT_RESP) flags[7] = 1'b0;
		else if (kind != RSP_BAD_ID) flags[7] = 1'b1;
		qd = $urandom_range(0, 2);
		an = (kind == RSP_NO_ANS) ? 0 : $urandom_range(1, 3);
		if (kind == RSP_BAD_ID || kind == RSP_NOT_RESP) an = $urandom_range(0, 2);
		if (kind == RSP_TRUNC && $urandom_range(0, 4) == 0) begin
			if ($urandom_range(0, 1) != 0) qd = 65535;
			else an = 65535;
		end
		add_u16(id);
		pkt_q.push_back(flags);
		pkt_q.push_back(8'($urandom));
		add_u16(16'(qd));
		add_u16(16'(an));
		add_u16(16'($urandom));
		add_u16(16'($urandom));
		if (kind == RSP_BAD_ID || kind == RSP_NOT_RESP || kind == RSP_NO_ANS) begin
			repeat ($urandom_range(0, 6)) pkt_q.push_back(8'($urandom));
			return;
		end

		// Questions, then answers with at most one planted IPv4 record
		qd_n = (qd > 2) ? 2 : qd;
		an_n = (an > 3) ? 3 : an;
		repeat (qd_n) begin
			add_name();
			add_u16(16'($urandom));
			add_u16(16'($urandom));
		end
		hit = (kind == RSP_NO_A) ? -1 : $urandom_range(0, an_n - 1);
		if (kind == RSP_TRUNC && $urandom_range(0, 1) != 0) hit = -1;
		for (int i = 0; i < an_n; i++) begin
			add_name();
			if (i == hit) begin
				add_u16(TYPE_A);
				add_u16(CLASS_IN);
				add_u16(16'($urandom));
				add_u16(16'($urandom));
				add_u16(LEN_IPV4);
				add_u16(addr[31:16]);
				add_u16(addr[15:0]);
			end else begin
				add_other_record();
			end
		end
		repeat ($urandom_range(0, 3)) pkt_q.push_back(8'($urandom));

		// Cut the message short somewhere after the header
		if (kind == RSP_TRUNC) begin
			cut = $urandom_range(12, pkt_q.size() - 2);
			while (pkt_q.size() > cut + 1) void'(pkt_q.pop_back());
		end
	endtask

	// Write the id register once the parser has gone quiet
	task automatic set_tid(input logic [15:0] v);
		msg_ch.valid <= 1'b0;
		while (chk_outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		tid_we   <= 1'b1;
		tid_data <= v;
		@(negedge clk);
		tid_we   <= 1'b0;
		cur_tid = v;
	endtask

	// Random stalls on the result side
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = pick_gap(60);
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (msg_ch.valid && msg_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		pkt_kind_e drill[7];
		pkt_kind_e kind;
		int goal;
		int r;
		drill = '{RSP_BAD_ID, RSP_NOT_RESP, RSP_NO_ANS, RSP_NO_A, RSP_TRUNC, RSP_SHORT,
			RSP_NOISE};
		arst_n           = 1'b0;
		tid_we           = 1'b0;
		tid_data         = '0;
		msg_ch.valid     = 1'b0;
		msg_ch.action    = 1'b0;
		msg_ch.data_byte = '0;
		msg_ch.last_byte = 1'b0;
		res_ch.ready     = 1'b0;
		cur_tid          = TID_RESET;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed: lone byte, clear, extreme addresses, each failure kind
		pkt_q.delete();
		pkt_q.push_back(8'hFF);
		send_packet();
		push_byte(1'b1, 8'h00, 1'b1);
		make_response(RSP_GOOD, 32'hFFFF_FFFF);
		send_packet();
		make_response(RSP_GOOD, 32'h0000_0000);
		send_packet();
		foreach (drill[i]) begin
			make_response(drill[i], $urandom);
			send_packet();
		end
		push_byte(1'b1, 8'hFF, 1'b0);
		make_response(RSP_NO_A, $urandom);
		send_packet();

		// Random: several id settings, extremes first
		for (int p = 0; p < 4; p++) begin
			set_tid((p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom));
			goal = sent + PHASE_BYTES;
			while (sent < goal) begin
				r = $urandom_range(0, 99);
				if (r < 40) kind = RSP_GOOD;
				else if (r < 52) kind = RSP_NO_A;
				else if (r < 66) kind = RSP_TRUNC;
				else if (r < 72) kind = RSP_BAD_ID;
				else if (r < 78) kind = RSP_NOT_RESP;
				else if (r < 84) kind = RSP_NO_ANS;
				else if (r < 92) kind = RSP_SHORT;
				else kind = RSP_NOISE;
				make_response(kind, $urandom);
				send_packet();
			end
		end

		// Drain and give the verdict
		msg_ch.valid <= 1'b0;
		while (chk_outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (chk_errors == 0 && chk_outstanding == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/dnsap_pkg.sv
rtl/dnsap_msg_if.sv
rtl/dnsap_res_if.sv
rtl/dnsap_core.sv
rtl/dnsap_res_buf.sv
rtl/dns_response_a_record_parser_top.sv
verif/dnsap_answer_checker.sv
verif/dns_response_a_record_parser_top_tb.sv
